/* src/infix_to_postfix_converter_unit_assert.svh */
// Assertion macros used by the converter's top-level RTL file.
// Every check is clocked on clk and is held off while rst_n is low.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define IPC_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define IPC_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* src/ipc_pkg.sv */
`timescale 1ns / 1ps

package ipc_pkg;

    // Default operator stack depth.
    localparam int STACK_DEPTH_DEF = 32;

    // Depth of the command queue between the front and back parts.
    localparam int Q_DEPTH = 2;

    // Characters with a special meaning.
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_MOD   = 8'h25;
    localparam logic [7:0] CH_POW   = 8'h5E;

    // Precedence levels.
    localparam logic [2:0] PREC_NONE = 3'd0;
    localparam logic [2:0] PREC_OPEN = 3'd1;
    localparam logic [2:0] PREC_ADD  = 3'd2;
    localparam logic [2:0] PREC_MUL  = 3'd3;
    localparam logic [2:0] PREC_POW  = 3'd4;

    // Error codes carried in a result word.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_CLOSE    = 2'd2;
    localparam logic [1:0] ERR_OPEN     = 2'd3;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_expression;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       last_of_run;
        logic       expression_done;
        logic [1:0] error_code;
    } out_word_t;

    // Class of an accepted character.
    typedef enum logic [2:0] {
        K_OPERAND,
        K_OPEN,
        K_CLOSE,
        K_OPER,
        K_END
    } kind_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic [2:0] prec;
    } cmd_t;

    typedef enum logic {
        BK_RUN,
        BK_FLUSH
    } back_state_t;

    // Precedence of a character; operands get PREC_NONE.
    function automatic logic [2:0] prec_of(input logic [7:0] c);
        logic [2:0] p;
        case (c)
            CH_OPEN:                  p = PREC_OPEN;
            CH_ADD, CH_SUB:           p = PREC_ADD;
            CH_MUL, CH_DIV, CH_MOD:   p = PREC_MUL;
            CH_POW:                   p = PREC_POW;
            default:                  p = PREC_NONE;
        endcase
        return p;
    endfunction

endpackage

/* src/ipc_ram.sv */
`timescale 1ns / 1ps

module ipc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port and registered read port; read data holds when idle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/ipc_front.sv */
`timescale 1ns / 1ps

module ipc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  ipc_pkg::in_word_t item,
    input  logic             item_valid,
    output logic             item_ready,
    output ipc_pkg::cmd_t    cmd,
    output logic             cmd_valid,
    input  logic             cmd_ready
);

    logic          stage_valid_reg;
    logic          stage_valid_next;
    ipc_pkg::cmd_t stage_reg;
    ipc_pkg::cmd_t stage_next;
    logic          take;
    logic [2:0]    p;

    // The stage takes a new word whenever it is empty or being drained.
    assign item_ready = !stage_valid_reg || cmd_ready;
    assign take       = item_valid && item_ready;

    // Classify the incoming character.
    always_comb
    begin
        p               = ipc_pkg::prec_of(item.in_char);
        stage_next.ch   = item.in_char;
        stage_next.prec = p;
        if (item.end_of_expression)
        begin
            stage_next.kind = ipc_pkg::K_END;
        end
        else if (item.in_char == ipc_pkg::CH_OPEN)
        begin
            stage_next.kind = ipc_pkg::K_OPEN;
        end
        else if (item.in_char == ipc_pkg::CH_CLOSE)
        begin
            stage_next.kind = ipc_pkg::K_CLOSE;
        end
        else if (p >= ipc_pkg::PREC_ADD)
        begin
            stage_next.kind = ipc_pkg::K_OPER;
        end
        else
        begin
            stage_next.kind = ipc_pkg::K_OPERAND;
        end
    end

    // Valid flag of the stage.
    always_comb
    begin
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg <= stage_next;
        end
    end

    assign cmd       = stage_reg;
    assign cmd_valid = stage_valid_reg;

endmodule

/* src/ipc_queue.sv */
`timescale 1ns / 1ps

module ipc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  ipc_pkg::cmd_t wr_data,
    input  logic          wr_valid,
    output logic          wr_ready,
    output ipc_pkg::cmd_t rd_data,
    output logic          rd_valid,
    input  logic          rd_pop
);

    localparam int PW = $clog2(ipc_pkg::Q_DEPTH);
    localparam int FW = $clog2(ipc_pkg::Q_DEPTH + 1);

    ipc_pkg::cmd_t   entry_reg [ipc_pkg::Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;
    logic            do_wr;
    logic            do_rd;

    assign wr_ready = (fill_reg != FW'(ipc_pkg::Q_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    // Pointer and fill level updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(ipc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(ipc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/ipc_back.sv */
`timescale 1ns / 1ps

module ipc_back #(
    parameter int STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ipc_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    output ipc_pkg::out_word_t result,
    output logic               result_valid,
    input  logic               result_ready
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    ipc_pkg::back_state_t state_reg;
    ipc_pkg::back_state_t state_next;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      count_m2;
    logic [7:0]         top_reg;
    logic [7:0]         top_next;
    logic               top_from_ram_reg;
    logic               top_from_ram_next;
    logic [7:0]         top_c;
    logic [7:0]         ram_rd_data;
    logic               ram_rd_en;

    ipc_pkg::out_word_t hold_reg;
    ipc_pkg::out_word_t hold_next;
    logic               hold_valid_reg;
    logic               hold_valid_next;
    ipc_pkg::out_word_t out_reg;
    ipc_pkg::out_word_t out_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic               out_free;
    logic               step;
    logic               fin;
    logic               do_push;
    logic               do_pop;
    logic               res_valid;
    ipc_pkg::out_word_t res_word;
    logic               stack_empty;
    logic               stack_full;
    logic               load_out;

    // Operator stack storage.
    ipc_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cmd.ch),
        .rd_en   (ram_rd_en),
        .rd_addr (count_m2[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Top of stack: the last pushed character, or the entry read back after a pop.
    assign top_c       = top_from_ram_reg ? ram_rd_data : top_reg;
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg >= CW'(STACK_DEPTH));
    assign count_m2    = count_reg - CW'(2);
    assign ram_rd_en   = do_pop && (count_reg > CW'(1));
    assign out_free    = !out_valid_reg || result_ready;

    // One step of the current command: at most one pop or push, and at most one result.
    always_comb
    begin
        res_valid = 1'b0;
        res_word  = '0;
        fin       = 1'b0;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        step      = (state_reg == ipc_pkg::BK_RUN) && cmd_valid
                    && (!hold_valid_reg || out_free);
        if (step)
        begin
            case (cmd.kind)
                ipc_pkg::K_END:
                begin
                    res_valid = 1'b1;
                    if (!stack_empty)
                    begin
                        do_pop            = 1'b1;
                        res_word.out_char = top_c;
                        if (top_c == ipc_pkg::CH_OPEN)
                        begin
                            res_word.error_code = ipc_pkg::ERR_OPEN;
                        end
                        else
                        begin
                            res_word.char_valid = 1'b1;
                        end
                    end
                    else
                    begin
                        res_word.expression_done = 1'b1;
                        fin                      = 1'b1;
                    end
                end
                ipc_pkg::K_OPEN:
                begin
                    fin = 1'b1;
                    if (stack_full)
                    begin
                        res_valid           = 1'b1;
                        res_word.error_code = ipc_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        do_push = 1'b1;
                    end
                end
                ipc_pkg::K_CLOSE:
                begin
                    if (stack_empty)
                    begin
                        res_valid           = 1'b1;
                        res_word.error_code = ipc_pkg::ERR_CLOSE;
                        fin                 = 1'b1;
                    end
                    else if (top_c == ipc_pkg::CH_OPEN)
                    begin
                        do_pop = 1'b1;
                        fin    = 1'b1;
                    end
                    else
                    begin
                        do_pop              = 1'b1;
                        res_valid           = 1'b1;
                        res_word.out_char   = top_c;
                        res_word.char_valid = 1'b1;
                    end
                end
                ipc_pkg::K_OPER:
                begin
                    if (!stack_empty && (ipc_pkg::prec_of(top_c) >= cmd.prec))
                    begin
                        do_pop              = 1'b1;
                        res_valid           = 1'b1;
                        res_word.out_char   = top_c;
                        res_word.char_valid = 1'b1;
                    end
                    else if (stack_full)
                    begin
                        res_valid           = 1'b1;
                        res_word.error_code = ipc_pkg::ERR_OVERFLOW;
                        fin                 = 1'b1;
                    end
                    else
                    begin
                        do_push = 1'b1;
                        fin     = 1'b1;
                    end
                end
                default:
                begin
                    res_valid           = 1'b1;
                    res_word.out_char   = cmd.ch;
                    res_word.char_valid = 1'b1;
                    fin                 = 1'b1;
                end
            endcase
        end
    end

    assign cmd_pop = step && fin;

    // Next state: after a command ends, the held result leaves with its last mark.
    always_comb
    begin
        case (state_reg)
            ipc_pkg::BK_RUN:
            begin
                if (step && fin && (res_valid || hold_valid_reg))
                begin
                    state_next = ipc_pkg::BK_FLUSH;
                end
                else
                begin
                    state_next = ipc_pkg::BK_RUN;
                end
            end
            ipc_pkg::BK_FLUSH:
            begin
                state_next = out_free ? ipc_pkg::BK_RUN : ipc_pkg::BK_FLUSH;
            end
            default:
            begin
                state_next = ipc_pkg::BK_RUN;
            end
        endcase
    end

    // Stack pointer and cached top.
    always_comb
    begin
        count_next        = count_reg;
        top_next          = top_reg;
        top_from_ram_next = top_from_ram_reg;
        if (do_push)
        begin
            count_next        = count_reg + 1'b1;
            top_next          = cmd.ch;
            top_from_ram_next = 1'b0;
        end
        else if (do_pop)
        begin
            count_next = count_reg - 1'b1;
            if (ram_rd_en)
            begin
                top_from_ram_next = 1'b1;
            end
        end
    end

    // A result waits in the hold register until it is known whether it ends the run.
    always_comb
    begin
        load_out        = (step && res_valid && hold_valid_reg)
                          || ((state_reg == ipc_pkg::BK_FLUSH) && out_free);
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = hold_reg;
        if (step && res_valid)
        begin
            hold_next       = res_word;
            hold_valid_next = 1'b1;
        end
        else if ((state_reg == ipc_pkg::BK_FLUSH) && out_free)
        begin
            hold_valid_next      = 1'b0;
            out_next.last_of_run = 1'b1;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ipc_pkg::BK_RUN;
            count_reg        <= '0;
            top_from_ram_reg <= 1'b0;
            hold_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            top_from_ram_reg <= top_from_ram_next;
            hold_valid_reg   <= hold_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        hold_reg <= hold_next;
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

/* src/infix_to_postfix_converter_unit.sv */
// Infix to postfix converter (shunting-yard), one character per input word.
// Input channel: item_valid / item_ready carry item (in_char, end_of_expression).
// Output channel: result_valid / result_ready carry result words (out_char,
// char_valid, last_of_run, expression_done, error_code). One input word gives
// zero or more result words; the last one of a run has last_of_run set, and an
// end word always closes with expression_done.
// Path: front stage register, command queue, hold register, output register.
// Flow: each stack pop is a step of its own in the execution unit, and a command that
// emits results ends with an extra flush step to mark the last result. Popping is
// limited to one entry per cycle, while the output is not stalled, by the single
// read port of the stack RAM. A two-word command queue lets the input side run
// ahead of the execution unit.
// Reset empties the operator stack, the command queue and the output register.
// When the receiver stalls, the current result word holds, the execution unit
// stops, the queue fills and item_ready drops.
`timescale 1ns / 1ps

`include "infix_to_postfix_converter_unit_assert.svh"

module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ipc_pkg::in_word_t  item,
    input  logic               item_valid,
    output logic               item_ready,
    output ipc_pkg::out_word_t result,
    output logic               result_valid,
    input  logic               result_ready
);

    ipc_pkg::cmd_t f_cmd;
    logic          f_valid;
    logic          q_ready;
    ipc_pkg::cmd_t q_cmd;
    logic          q_valid;
    logic          q_pop;

    // Front part: accepts and classifies characters.
    ipc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (f_cmd),
        .cmd_valid  (f_valid),
        .cmd_ready  (q_ready)
    );

    // Command queue between front and back.
    ipc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (f_cmd),
        .wr_valid (f_valid),
        .wr_ready (q_ready),
        .rd_data  (q_cmd),
        .rd_valid (q_valid),
        .rd_pop   (q_pop)
    );

    // Back part: runs the operator stack and emits result words.
    ipc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (q_cmd),
        .cmd_valid    (q_valid),
        .cmd_pop      (q_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // Checks on the internal hand-off and on result word coding.
    `IPC_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "command popped from an empty queue")
    `IPC_ASSERT_NEXT(a_front_holds, f_valid && !q_ready, f_valid && $stable(f_cmd), "front dropped a stalled command")
    `IPC_ASSERT_NOW(a_done_is_last, result_valid && result.expression_done, result.last_of_run, "done marker without last mark")
    `IPC_ASSERT_NOW(a_char_no_error, result_valid && result.char_valid, result.error_code == ipc_pkg::ERR_NONE, "character word carries an error")
    `IPC_ASSERT_NOW(a_open_coding, result_valid && (result.error_code == ipc_pkg::ERR_OPEN), !result.char_valid && (result.out_char == ipc_pkg::CH_OPEN), "bad unmatched open word")

endmodule
